FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the RLE8 decoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define BRLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define BRLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/brle8_pkg.sv
// Shared types and constants of the RLE8 bitmap decoder.
// No dependencies; imported by the parser, the command queue, the address unit and the top.
package brle8_pkg;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned STRIDE_W     = 17;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned LEN_W        = 8;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(4);

  // Escape byte and the codes that may follow it
  localparam logic [7:0] ESC_BYTE   = 8'd0;
  localparam logic [7:0] CODE_EOL   = 8'd0;
  localparam logic [7:0] CODE_EOB   = 8'd1;
  localparam logic [7:0] CODE_DELTA = 8'd2;

  // One write command between parser and address unit
  typedef struct packed {
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] column;
    logic [PIX_W-1:0]  value;
    logic [LEN_W-1:0]  len;
    logic              eoi;
  } cmd_t;

endpackage

FILE: src/brle8_parser.sv
// Front part of the RLE8 decoder: parses the byte stream and tracks the position.
// Depends on brle8_pkg; pushes cmd_t commands into the command queue.
module brle8_parser
  import brle8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  output logic       byte_ready_o,
  input  logic [7:0] stream_byte_i,
  input  logic       frame_start_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);

  // Parser states
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_FILL_VALUE = 3'd1;
  localparam logic [2:0] PH_ESCAPE     = 3'd2;
  localparam logic [2:0] PH_DELTA_X    = 3'd3;
  localparam logic [2:0] PH_DELTA_Y    = 3'd4;
  localparam logic [2:0] PH_LITERAL    = 3'd5;
  localparam logic [2:0] PH_PAD        = 3'd6;
  localparam logic [2:0] PH_DONE       = 3'd7;

  logic [2:0]        phase_q, phase_d, phase_c;
  logic [ADDR_W-1:0] column_q, column_d, column_c;
  logic [ADDR_W-1:0] row_q, row_d, row_c;
  logic [7:0]        pending_q, pending_d, pending_c;
  logic              pad_q, pad_d, pad_c;
  logic              fire;
  logic              emit;
  logic [7:0]        pending_dec;

  assign byte_ready_o = cmd_ready_i;
  assign fire         = byte_valid_i & byte_ready_o;
  assign cmd_valid_o  = fire & emit;

  // Frame start clears position and parser before the byte is taken
  always_comb begin
    phase_c   = frame_start_i ? PH_IDLE : phase_q;
    column_c  = frame_start_i ? '0 : column_q;
    row_c     = frame_start_i ? '0 : row_q;
    pending_c = frame_start_i ? '0 : pending_q;
    pad_c     = frame_start_i ? 1'b0 : pad_q;
  end

  assign pending_dec = pending_c - 8'd1;

  // Next state and command for the current byte
  always_comb begin
    phase_d   = phase_c;
    column_d  = column_c;
    row_d     = row_c;
    pending_d = pending_c;
    pad_d     = pad_c;
    emit      = 1'b0;
    cmd_o     = '{row: row_c, column: column_c, value: stream_byte_i,
                  len: 8'd1, eoi: 1'b0};
    unique case (phase_c)
      PH_IDLE: begin
        if (stream_byte_i == ESC_BYTE) begin
          phase_d = PH_ESCAPE;
        end else begin
          pending_d = stream_byte_i;
          phase_d   = PH_FILL_VALUE;
        end
      end
      PH_FILL_VALUE: begin
        emit      = 1'b1;
        cmd_o.len = pending_c;
        column_d  = column_c + ADDR_W'(pending_c);
        pending_d = '0;
        phase_d   = PH_IDLE;
      end
      PH_ESCAPE: begin
        unique case (stream_byte_i)
          CODE_EOL: begin
            row_d    = row_c + ADDR_W'(1);
            column_d = '0;
            phase_d  = PH_IDLE;
          end
          CODE_EOB: begin
            emit    = 1'b1;
            cmd_o   = '{row: '0, column: '0, value: '0, len: '0, eoi: 1'b1};
            phase_d = PH_DONE;
          end
          CODE_DELTA: begin
            phase_d = PH_DELTA_X;
          end
          default: begin
            pending_d = stream_byte_i;
            pad_d     = stream_byte_i[0];
            phase_d   = PH_LITERAL;
          end
        endcase
      end
      PH_DELTA_X: begin
        column_d = column_c + ADDR_W'(stream_byte_i);
        phase_d  = PH_DELTA_Y;
      end
      PH_DELTA_Y: begin
        row_d   = row_c + ADDR_W'(stream_byte_i);
        phase_d = PH_IDLE;
      end
      PH_LITERAL: begin
        emit      = 1'b1;
        column_d  = column_c + ADDR_W'(1);
        pending_d = pending_dec;
        if (pending_dec == 8'd0) begin
          phase_d = pad_c ? PH_PAD : PH_IDLE;
          pad_d   = 1'b0;
        end
      end
      PH_PAD: begin
        phase_d = PH_IDLE;
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      column_q  <= '0;
      row_q     <= '0;
      pending_q <= '0;
      pad_q     <= 1'b0;
    end else if (fire) begin
      phase_q   <= phase_d;
      column_q  <= column_d;
      row_q     <= row_d;
      pending_q <= pending_d;
      pad_q     <= pad_d;
    end
  end

endmodule

FILE: src/brle8_fifo.sv
// Short command queue between parser and address unit.
// Depends on brle8_pkg for cmd_t; DEPTH must be a power of two, at least 2.
module brle8_fifo
  import brle8_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/brle8_addr.sv
// Back part of the RLE8 decoder: forms row*stride+column and holds the result beat.
// Depends on brle8_pkg; two registered stages, multiply then add.
module brle8_addr
  import brle8_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_t                cmd_i,
  input  logic [STRIDE_W-1:0] row_stride_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ADDR_W-1:0]   write_address_o,
  output logic [PIX_W-1:0]    pixel_value_o,
  output logic [LEN_W-1:0]    run_length_o,
  output logic                end_of_image_o
);

  logic                     s1_valid_q;
  logic [ADDR_W-1:0]        s1_prod_q, s1_column_q;
  logic [PIX_W-1:0]         s1_value_q;
  logic [LEN_W-1:0]         s1_len_q;
  logic                     s1_eoi_q;
  logic                     out_valid_q;
  logic [ADDR_W-1:0]        out_addr_q;
  logic [PIX_W-1:0]         out_value_q;
  logic [LEN_W-1:0]         out_len_q;
  logic                     out_eoi_q;
  logic                     out_free, s1_free;
  logic [ADDR_W+STRIDE_W-1:0] prod_full;

  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_free     = !s1_valid_q || out_free;
  assign cmd_ready_o = s1_free;
  assign prod_full   = cmd_i.row * row_stride_i;

  // Stage 1: multiply row by stride
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && cmd_valid_i) begin
      s1_prod_q   <= prod_full[ADDR_W-1:0];
      s1_column_q <= cmd_i.column;
      s1_value_q  <= cmd_i.value;
      s1_len_q    <= cmd_i.len;
      s1_eoi_q    <= cmd_i.eoi;
    end
  end

  // Stage 2: add column into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_addr_q  <= s1_prod_q + s1_column_q;
      out_value_q <= s1_value_q;
      out_len_q   <= s1_len_q;
      out_eoi_q   <= s1_eoi_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = out_addr_q;
  assign pixel_value_o   = out_value_q;
  assign run_length_o    = out_len_q;
  assign end_of_image_o  = out_eoi_q;

endmodule

FILE: src/bmp_rle8_decoder.sv
// RLE8 bitmap decoder: takes one compressed byte per beat on s_axis and sends
// frame buffer write commands on m_axis. The s_axis tdata carries stream_byte,
// tuser carries frame_start, which clears position and parser for that byte.
// m_axis tdata carries write_address [31:0], pixel_value [39:32] and
// run_length [47:40]; tuser carries end_of_image. A fill run gives one beat,
// every literal byte gives one beat of length 1, the end marker gives one
// beat with all data zero; escapes, deltas and pad bytes give none.
// The row stride is written through cfg_valid_i / cfg_data_i; the user must
// write it only while idle, the block does not enforce it. Throughput: one byte
// per cycle while the queue has room; a beat passes queue, multiply, add stages.
// s_axis_tready drops only when the command queue is full, which happens when
// m_axis_tready stays low; the output register and the queue absorb the stall.
// Reset clears parser, position, queue and pipeline; the stride returns to 4.
// Depends on brle8_pkg, brle8_parser, brle8_fifo, brle8_addr, assert_macros.svh.
`include "assert_macros.svh"

module bmp_rle8_decoder
  import brle8_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel: row_stride
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [STRIDE_W-1:0] cfg_data_i,
  // Compressed byte stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] stream_byte
  input  logic                s_axis_tuser,  // [0] frame_start
  // Write commands
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,  // [31:0] write_address, [39:32] pixel_value,
                                             // [47:40] run_length
  output logic                m_axis_tuser   // [0] end_of_image
);

  logic [STRIDE_W-1:0] stride_q;
  logic                par_valid, par_ready;
  cmd_t                par_cmd;
  logic                q_valid, q_ready;
  cmd_t                q_cmd;
  logic [ADDR_W-1:0]   wr_addr;
  logic [PIX_W-1:0]    pix;
  logic [LEN_W-1:0]    run_len;
  logic                eoi;

  // Stride register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stride_q <= cfg_data_i;
    end
  end

  // Front: byte parser
  brle8_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (s_axis_tvalid),
    .byte_ready_o  (s_axis_tready),
    .stream_byte_i (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .cmd_valid_o   (par_valid),
    .cmd_o         (par_cmd),
    .cmd_ready_i   (par_ready)
  );

  // Command queue
  brle8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (par_valid),
    .push_ready_o (par_ready),
    .push_data_i  (par_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // Back: address formation and output register
  brle8_addr u_addr (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_ready_o     (q_ready),
    .cmd_i           (q_cmd),
    .row_stride_i    (stride_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .write_address_o (wr_addr),
    .pixel_value_o   (pix),
    .run_length_o    (run_len),
    .end_of_image_o  (eoi)
  );

  assign m_axis_tdata = {run_len, pix, wr_addr};
  assign m_axis_tuser = eoi;

  // Checks
  `BRLE_ASSERT_IMPL(a_eoi_zero_data, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                    m_axis_tdata == 48'd0, "end-of-image beat carries nonzero data")
  `BRLE_ASSERT_IMPL(a_run_nonzero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
                    m_axis_tdata[47:40] != 8'd0, "pixel write beat with zero run length")
  `BRLE_ASSERT_NEXT(a_stride_write, clk_i, rst_ni, cfg_valid_i && cfg_ready_o,
                    stride_q == $past(cfg_data_i), "stride register missed a write")

endmodule

FILE: sim/tb.sv
// Testbench for bmp_rle8_decoder: sends RLE8 byte streams on s_axis, predicts every
// write command and checks each m_axis beat against it. Depends on brle8_pkg.
`timescale 1ns / 100ps

module tb;
  import brle8_pkg::*;

  localparam logic [STRIDE_W-1:0] STRIDE_MIN  = STRIDE_W'(4);
  localparam logic [STRIDE_W-1:0] STRIDE_MAX  = STRIDE_W'(65536);
  localparam logic [STRIDE_W-1:0] STRIDE_ONES = '1;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 20;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum logic [2:0] {
    ST_COUNT, ST_FILL_VALUE, ST_ESCAPE, ST_DELTA_X,
    ST_DELTA_Y, ST_LITERAL, ST_PAD, ST_DONE
  } parse_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  value;
    logic [LEN_W-1:0]  len;
    logic              eoi;
  } write_cmd_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [STRIDE_W-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [7:0] stream_byte
  logic                s_axis_tuser  = 1'b0;  // [0] frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [47:0]         m_axis_tdata;  // [31:0] write_address, [39:32] pixel_value,
                                      // [47:40] run_length
  logic                m_axis_tuser;  // [0] end_of_image

  // Decoder state as predicted from the accepted bytes
  parse_state_e        dec_state;
  logic [31:0]         dec_column;
  logic [31:0]         dec_row;
  logic [7:0]          dec_pending;
  logic                dec_pad;
  logic [STRIDE_W-1:0] dec_stride;

  write_cmd_t  expected_writes[$];
  int unsigned bytes_sent     = 0;
  int unsigned beats_checked  = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 14;
  int unsigned recv_stall_pct = 87;
  logic        frame_pending  = 1'b0;

  bmp_rle8_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the write command side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [31:0] frame_address();
    return dec_row * {{(32 - STRIDE_W){1'b0}}, dec_stride} + dec_column;
  endfunction

  // Advance the predicted decoder by one byte and queue the write it causes
  task automatic decode_byte(input logic [7:0] b, input logic fs);
    if (fs) begin
      dec_state   = ST_COUNT;
      dec_column  = '0;
      dec_row     = '0;
      dec_pending = '0;
      dec_pad     = 1'b0;
    end
    case (dec_state)
      ST_COUNT: begin
        if (b == ESC_BYTE) begin
          dec_state = ST_ESCAPE;
        end else begin
          dec_pending = b;
          dec_state   = ST_FILL_VALUE;
        end
      end
      ST_FILL_VALUE: begin
        expected_writes.push_back(write_cmd_t'{addr: frame_address(), value: b,
                                               len: dec_pending, eoi: 1'b0});
        dec_column  = dec_column + 32'(dec_pending);
        dec_pending = '0;
        dec_state   = ST_COUNT;
      end
      ST_ESCAPE: begin
        if (b == CODE_EOL) begin
          dec_row    = dec_row + 32'd1;
          dec_column = '0;
          dec_state  = ST_COUNT;
        end else if (b == CODE_EOB) begin
          dec_state = ST_DONE;
          expected_writes.push_back(write_cmd_t'{addr: '0, value: '0, len: '0, eoi: 1'b1});
        end else if (b == CODE_DELTA) begin
          dec_state = ST_DELTA_X;
        end else begin
          dec_pending = b;
          dec_pad     = b[0];
          dec_state   = ST_LITERAL;
        end
      end
      ST_DELTA_X: begin
        dec_column = dec_column + 32'(b);
        dec_state  = ST_DELTA_Y;
      end
      ST_DELTA_Y: begin
        dec_row   = dec_row + 32'(b);
        dec_state = ST_COUNT;
      end
      ST_LITERAL: begin
        expected_writes.push_back(write_cmd_t'{addr: frame_address(), value: b,
                                               len: LEN_W'(1), eoi: 1'b0});
        dec_column  = dec_column + 32'd1;
        dec_pending = dec_pending - 8'd1;
        if (dec_pending == 8'd0) begin
          dec_state = dec_pad ? ST_PAD : ST_COUNT;
          dec_pad   = 1'b0;
        end
      end
      ST_PAD: begin
        dec_state = ST_COUNT;
      end
      default: ;  // after end of bitmap: ignore until a frame start
    endcase
  endtask

  // Compare each write beat with the oldest expected write
  always @(posedge clk_i) begin : check_writes
    write_cmd_t got;
    write_cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = write_cmd_t'{addr: m_axis_tdata[31:0], value: m_axis_tdata[39:32],
                         len: m_axis_tdata[47:40], eoi: m_axis_tuser};
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected write beat: addr=%h value=%h len=%0d eoi=%b",
                   got.addr, got.value, got.len, got.eoi);
      end else begin
        want = expected_writes.pop_front();
        if (got.addr !== want.addr || got.value !== want.value ||
            got.len !== want.len || got.eoi !== want.eoi) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("beat %0d: want %h/%h/%0d/%b got %h/%h/%0d/%b (addr/value/len/eoi)",
                     beats_checked, want.addr, want.value, want.len, want.eoi,
                     got.addr, got.value, got.len, got.eoi);
        end
      end
      beats_checked++;
    end
  end

  // Drive one byte, idling at random first, and predict it once accepted
  task automatic send_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= fs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, fs);
    bytes_sent++;
  endtask

  // Send a byte, marking it as frame start if a new frame is due
  task automatic put(input logic [7:0] b);
    send_byte(b, frame_pending);
    frame_pending = 1'b0;
  endtask

  // Hold the byte stream until every expected write has come out
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_stride(input logic [STRIDE_W-1:0] stride);
    pause_until_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= stride;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dec_stride = stride;
  endtask

  task automatic put_fill(input logic [7:0] count, input logic [7:0] value);
    put(count);
    put(value);
  endtask

  task automatic put_escape(input logic [7:0] code);
    put(ESC_BYTE);
    put(code);
  endtask

  task automatic put_delta(input logic [7:0] dx, input logic [7:0] dy);
    put_escape(CODE_DELTA);
    put(dx);
    put(dy);
  endtask

  // Literal run with random content and its pad byte when odd
  task automatic put_literal(input logic [7:0] count);
    put_escape(count);
    repeat (count) put(8'($urandom_range(255)));
    if (count[0]) put(8'($urandom_range(255)));
  endtask

  function automatic logic [STRIDE_W-1:0] pick_stride();
    case ($urandom_range(5))
      0:       return STRIDE_MIN;
      1:       return STRIDE_MAX;
      2:       return '0;
      3:       return STRIDE_ONES;
      default: return STRIDE_W'($urandom_range(65536, 4));
    endcase
  endfunction

  // Mostly well-formed frame with random content, some noise and broken runs
  task automatic random_frame();
    int unsigned n_ops;
    int unsigned kind;
    logic [7:0]  count;
    frame_pending = 1'b1;
    n_ops = $urandom_range(12, 2);
    repeat (n_ops) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        put_fill(8'($urandom_range(255, 1)), 8'($urandom_range(255)));
      end else if (kind < 52) begin
        put_escape(CODE_EOL);
      end else if (kind < 62) begin
        put_delta(8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (kind < 88) begin
        count = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 3))
                                          : 8'($urandom_range(12, 3));
        put_literal(count);
      end else if (kind < 94) begin
        repeat ($urandom_range(4, 1)) put(8'($urandom_range(255)));
      end else begin
        // break off a literal run and restart the frame
        put_escape(8'($urandom_range(255, 3)));
        repeat ($urandom_range(2)) put(8'($urandom_range(255)));
        frame_pending = 1'b1;
      end
    end
    if ($urandom_range(9) != 0) begin
      put_escape(CODE_EOB);
      repeat ($urandom_range(3)) put(8'($urandom_range(255)));
    end
  endtask

  // Field extremes, every escape code, odd and even literal runs, bytes after end
  task automatic test_directed();
    frame_pending = 1'b1;
    put_fill(8'd1, 8'h00);
    put_fill(8'd255, 8'hFF);
    put_escape(CODE_EOL);
    put_delta(8'hFF, 8'hFF);
    put_escape(8'd3);
    put(8'hA5);
    put(8'h5A);
    put(8'hFF);
    put(8'h00);
    put_escape(8'd4);
    put(8'h00);
    put(8'h01);
    put(8'h80);
    put(8'h7F);
    put_escape(CODE_EOB);
    put(8'h01);
  endtask

  // Push the row far enough that row * stride wraps past 2^32
  task automatic test_address_wrap();
    write_stride(STRIDE_ONES);
    frame_pending = 1'b1;
    put_fill(8'd3, 8'h3C);
    for (int i = 0; i < 130; i++) begin
      put_delta(8'hFF, 8'hFF);
      if (i % 10 == 9) put_fill(8'($urandom_range(255, 1)), 8'($urandom_range(255)));
    end
    put_literal(8'd3);
    put_escape(CODE_EOB);
  endtask

  task automatic test_random_frames(input int unsigned idle_in, input int unsigned stall_out,
                                    input logic [STRIDE_W-1:0] first_stride,
                                    input int unsigned budget);
    int unsigned stop_at;
    send_idle_pct  = idle_in;
    recv_stall_pct = stall_out;
    write_stride(first_stride);
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(7) == 0) write_stride(pick_stride());
      else if ($urandom_range(9) == 0) pause_until_drained();
      random_frame();
    end
  endtask

  initial begin
    dec_state   = ST_COUNT;
    dec_column  = '0;
    dec_row     = '0;
    dec_pending = '0;
    dec_pad     = 1'b0;
    dec_stride  = STRIDE_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_address_wrap();
    test_random_frames(14, 87, STRIDE_MAX, 440);
    test_random_frames(87, 14, '0, 440);
    test_random_frames(0, 0, STRIDE_MIN, 440);

    // Drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
